// ===== rtl/ray_box_slab_test_core_defines.svh =====
// assertion macros shared by the ray box slab test rtl
`ifndef RAY_BOX_SLAB_TEST_CORE_DEFINES_SVH
`define RAY_BOX_SLAB_TEST_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define RBST_ASSERT_IMP(name, ck, rn, ante, cons, msg) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define RBST_ASSERT_NEXT(name, ck, rn, ante, cons, msg) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rbst_pkg.sv =====
// shared constants and types of the ray box slab test
package rbst_pkg;

	localparam int COORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int CFG_IDX_W      = 3;
	localparam int NAXES          = 3;
	localparam int NLANES         = 6;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X,
		REG_ORIGIN_Y,
		REG_ORIGIN_Z,
		REG_DIR_X,
		REG_DIR_Y,
		REG_DIR_Z,
		REG_MARGIN,
		REG_SKIN_INSIDE
	} cfg_reg_t;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	typedef struct packed {
		logic valid;
		logic org_in;
	} item_ctl_t;

endpackage

// ===== rtl/ray_box_slab_test_core.sv =====
// top level of the ray box slab test: config registers, pipeline, output buffer
`include "ray_box_slab_test_core_defines.svh"

// Tests one axis-aligned box per cycle while s_axis_tready is high against the configured
// segment using the slab method in signed fixed point. A new box may be offered every
// cycle. The restoring divider resolves one quotient bit per stage for all six slab
// distances at once, between three front and five back stages. Results leave in order
// through a two-entry output buffer; s_axis_tready falls only while both entries are held,
// and the whole pipeline then waits. Configuration is written through cfg_we, cfg_index and
// cfg_data and must only change while no box is in flight.
module ray_box_slab_test_core #(
	parameter int COORD_BITS = rbst_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = rbst_pkg::FRAC_BITS_DEF,
	localparam int IN_W   = 6*COORD_BITS + 3*(COORD_BITS-2),
	localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
	localparam int OUT_W  = 5*COORD_BITS + 4,
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, grow_x, grow_y,
	// grow_z
	input  logic [IN_TW-1:0]               s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// did_hit, origin_inside, entry_time, exit_time, entry_axis, normal_negative,
	// point_x, point_y, point_z
	output logic [OUT_TW-1:0]              m_axis_tdata,
	input  logic                           cfg_we,
	input  logic [rbst_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]          cfg_data
);
	import rbst_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int GW = CB - 2;

	logic signed [CB-1:0] org_q [NAXES];
	logic signed [CB-1:0] dir_q [NAXES];
	logic        [CB-2:0] margin_q;
	logic                 skin_q;

	logic        [CB-1:0] dmag_c [NAXES];
	logic                 dneg_c [NAXES];
	logic                 dzero_c [NAXES];
	logic signed [CB-1:0] box_min_c [NAXES];
	logic signed [CB-1:0] box_max_c [NAXES];
	logic        [GW-1:0] grow_c [NAXES];

	logic                 en;
	item_ctl_t            front_ctl, div_ctl;
	logic        [CB+1:0] diff_mag [NLANES];
	logic                 diff_neg [NLANES];
	logic signed [CB-1:0] slab_t [NLANES];

	logic                 res_valid, res_hit, res_inside, res_nn;
	logic        [CB-2:0] res_entry;
	logic signed [CB-1:0] res_exit;
	logic           [1:0] res_axis;
	logic signed [CB-1:0] res_point [NAXES];
	logic     [OUT_W-1:0] res_c;

	logic     [OUT_W-1:0] head_q, skid_q;
	logic           [1:0] cnt_q;
	logic                 push, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NAXES; i++) begin
				org_q[i] <= '0;
				dir_q[i] <= '0;
			end
			margin_q <= '0;
			skin_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ORIGIN_X:    org_q[0] <= cfg_data;
				REG_ORIGIN_Y:    org_q[1] <= cfg_data;
				REG_ORIGIN_Z:    org_q[2] <= cfg_data;
				REG_DIR_X:       dir_q[0] <= cfg_data;
				REG_DIR_Y:       dir_q[1] <= cfg_data;
				REG_DIR_Z:       dir_q[2] <= cfg_data;
				REG_MARGIN:      margin_q <= cfg_data[CB-2:0];
				REG_SKIN_INSIDE: skin_q   <= cfg_data[0];
				default:         skin_q   <= skin_q;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < NAXES; i++) begin
			dneg_c[i]    = dir_q[i][CB-1];
			dzero_c[i]   = dir_q[i] == '0;
			dmag_c[i]    = dneg_c[i] ? CB'(-dir_q[i]) : CB'(dir_q[i]);
			box_min_c[i] = s_axis_tdata[i*CB +: CB];
			box_max_c[i] = s_axis_tdata[(NAXES+i)*CB +: CB];
			grow_c[i]    = s_axis_tdata[2*NAXES*CB + i*GW +: GW];
		end
	end

	// pipeline moves unless both buffer entries are taken
	assign en            = cnt_q != 2'd2;
	assign s_axis_tready = en;

	rbst_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_axis_tvalid),
		.box_min  (box_min_c),
		.box_max  (box_max_c),
		.grow     (grow_c),
		.org      (org_q),
		.dneg     (dneg_c),
		.margin   (margin_q),
		.skin     (skin_q),
		.ctl      (front_ctl),
		.diff_mag (diff_mag),
		.diff_neg (diff_neg)
	);

	rbst_div #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctl_in   (front_ctl),
		.diff_mag (diff_mag),
		.diff_neg (diff_neg),
		.dmag     (dmag_c),
		.dneg     (dneg_c),
		.dzero    (dzero_c),
		.ctl_out  (div_ctl),
		.slab_t   (slab_t)
	);

	rbst_back #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.ctl_in          (div_ctl),
		.slab_t          (slab_t),
		.org             (org_q),
		.dmag            (dmag_c),
		.dneg            (dneg_c),
		.res_valid       (res_valid),
		.did_hit         (res_hit),
		.origin_inside   (res_inside),
		.entry_time      (res_entry),
		.exit_time       (res_exit),
		.entry_axis      (res_axis),
		.normal_negative (res_nn),
		.point           (res_point)
	);

	assign res_c = {res_point[2], res_point[1], res_point[0], res_nn, res_axis,
		res_exit, res_entry, res_inside, res_hit};

	// two-entry output buffer, head drives the master side
	assign push = en && res_valid;
	assign pop  = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (cnt_q == 2'd2) begin
				head_q <= skid_q;
			end else if (push) begin
				head_q <= res_c;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				head_q <= res_c;
			end else begin
				skid_q <= res_c;
			end
		end
	end

	assign m_axis_tvalid = cnt_q != 2'd0;
	assign m_axis_tdata  = OUT_TW'(head_q);

	`RBST_ASSERT_IMP(a_stall_holds_result, clk, arst_n, !s_axis_tready, m_axis_tvalid, "input stalled with no result waiting")
	`RBST_ASSERT_IMP(a_hit_not_inside, clk, arst_n, m_axis_tvalid, !(head_q[0] && head_q[1]), "hit reported with origin inside")
	`RBST_ASSERT_IMP(a_axis_code, clk, arst_n, m_axis_tvalid, axis_t'(head_q[2*CB+1 +: 2]) == AXIS_X || axis_t'(head_q[2*CB+1 +: 2]) == AXIS_Y || axis_t'(head_q[2*CB+1 +: 2]) == AXIS_Z, "entry axis out of range")
	`RBST_ASSERT_NEXT(a_full_drain, clk, arst_n, cnt_q == 2'd2 && m_axis_tready, cnt_q == 2'd1, "full buffer did not drain by one transfer")

endmodule

// ===== rtl/rbst_front.sv =====
// front stages: grown bounds, origin inside test, slab distances
module rbst_front #(
	parameter int COORD_BITS = rbst_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic signed [COORD_BITS-1:0] box_min [rbst_pkg::NAXES],
	input  logic signed [COORD_BITS-1:0] box_max [rbst_pkg::NAXES],
	input  logic        [COORD_BITS-3:0] grow [rbst_pkg::NAXES],
	input  logic signed [COORD_BITS-1:0] org [rbst_pkg::NAXES],
	input  logic                         dneg [rbst_pkg::NAXES],
	input  logic        [COORD_BITS-2:0] margin,
	input  logic                         skin,
	output rbst_pkg::item_ctl_t          ctl,
	output logic        [COORD_BITS+1:0] diff_mag [rbst_pkg::NLANES],
	output logic                         diff_neg [rbst_pkg::NLANES]
);
	import rbst_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int LW = CB + 1;
	localparam int BW = CB + 2;
	localparam int DW = CB + 3;
	localparam int AW = CB + 2;

	logic valid_s1, valid_s2, valid_s3;
	logic inside_s2, inside_s3;
	logic signed [LW-1:0] lo_s1 [NAXES];
	logic signed [LW-1:0] hi_s1 [NAXES];
	logic signed [BW-1:0] lob_s2 [NAXES];
	logic signed [BW-1:0] hib_s2 [NAXES];
	logic        [AW-1:0] mag_s3 [NLANES];
	logic                 neg_s3 [NLANES];
	logic                 inside_c;
	logic signed [DW-1:0] dif_c [NLANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// origin inside the grown box, surface counted by skin
	always_comb begin
		inside_c = 1'b1;
		for (int i = 0; i < NAXES; i++) begin
			if (skin) begin
				inside_c &= (lo_s1[i] <= LW'(org[i])) && (LW'(org[i]) <= hi_s1[i]);
			end else begin
				inside_c &= (lo_s1[i] < LW'(org[i])) && (LW'(org[i]) < hi_s1[i]);
			end
		end
	end

	// near slab first in each lane pair, far slab second
	always_comb begin
		for (int i = 0; i < NAXES; i++) begin
			dif_c[2*i]   = DW'(dneg[i] ? hib_s2[i] : lob_s2[i]) - DW'(org[i]);
			dif_c[2*i+1] = DW'(dneg[i] ? lob_s2[i] : hib_s2[i]) - DW'(org[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NAXES; i++) begin
				lo_s1[i]  <= LW'(box_min[i]) - LW'(grow[i]);
				hi_s1[i]  <= LW'(box_max[i]) + LW'(grow[i]);
				lob_s2[i] <= BW'(lo_s1[i]) - BW'(margin);
				hib_s2[i] <= BW'(hi_s1[i]) + BW'(margin);
			end
			inside_s2 <= inside_c;
			inside_s3 <= inside_s2;
			for (int k = 0; k < NLANES; k++) begin
				mag_s3[k] <= dif_c[k][DW-1] ? AW'(-dif_c[k]) : AW'(dif_c[k]);
				neg_s3[k] <= dif_c[k][DW-1];
			end
		end
	end

	assign ctl      = '{valid: valid_s3, org_in: inside_s3};
	assign diff_mag = mag_s3;
	assign diff_neg = neg_s3;

endmodule

// ===== rtl/rbst_div.sv =====
// pipelined restoring divider, one quotient bit per stage, six slab lanes
module rbst_div #(
	parameter int COORD_BITS = rbst_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = rbst_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  rbst_pkg::item_ctl_t          ctl_in,
	input  logic        [COORD_BITS+1:0] diff_mag [rbst_pkg::NLANES],
	input  logic                         diff_neg [rbst_pkg::NLANES],
	input  logic        [COORD_BITS-1:0] dmag [rbst_pkg::NAXES],
	input  logic                         dneg [rbst_pkg::NAXES],
	input  logic                         dzero [rbst_pkg::NAXES],
	output rbst_pkg::item_ctl_t          ctl_out,
	output logic signed [COORD_BITS-1:0] slab_t [rbst_pkg::NLANES]
);
	import rbst_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int AW = CB + 2;
	localparam int QB = CB - 1;
	localparam int SH = CB - 1 - FRAC_BITS;
	localparam int RW = CB + 1;
	localparam int CW = AW + SH;
	localparam int NS = QB + 1;
	localparam logic [CB-1:0] T_MAX = {1'b0, {(CB-1){1'b1}}};

	logic          valid_s [NS];
	logic          inside_s [NS];
	logic [RW-1:0] rem_s [NS][NLANES];
	logic [QB-1:0] quo_s [NS][NLANES];
	logic [QB-1:0] num_s [NS][NLANES];
	logic          sat_s [NS][NLANES];
	logic          sneg_s [NS][NLANES];
	logic          zero_s [NS][NLANES];
	logic          valid_sf, inside_sf;
	logic signed [CB-1:0] tval_sf [NLANES];

	logic          sat_c [NLANES];
	logic [RW-1:0] rsh_c [1:QB][NLANES];
	logic          ge_c [1:QB][NLANES];
	logic [CB-1:0] mag_c [NLANES];

	// quotient would reach the integer limit: saturate, parallel axes too
	always_comb begin
		for (int k = 0; k < NLANES; k++) begin
			sat_c[k] = dzero[k>>1] | (CW'(diff_mag[k]) >= (CW'(dmag[k>>1]) << SH));
		end
	end

	always_comb begin
		for (int s = 1; s < NS; s++) begin
			for (int k = 0; k < NLANES; k++) begin
				rsh_c[s][k] = {rem_s[s-1][k][RW-2:0], num_s[s-1][k][QB-1]};
				ge_c[s][k]  = rsh_c[s][k] >= RW'(dmag[k>>1]);
			end
		end
	end

	always_comb begin
		for (int k = 0; k < NLANES; k++) begin
			if (zero_s[QB][k]) begin
				mag_c[k] = '0;
			end else if (sat_s[QB][k]) begin
				mag_c[k] = T_MAX;
			end else begin
				mag_c[k] = CB'(quo_s[QB][k]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NS; s++) begin
				valid_s[s] <= 1'b0;
			end
			valid_sf <= 1'b0;
		end else if (en) begin
			valid_s[0] <= ctl_in.valid;
			for (int s = 1; s < NS; s++) begin
				valid_s[s] <= valid_s[s-1];
			end
			valid_sf <= valid_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inside_s[0] <= ctl_in.org_in;
			for (int k = 0; k < NLANES; k++) begin
				sat_s[0][k]  <= sat_c[k];
				rem_s[0][k]  <= sat_c[k] ? '0 : RW'(diff_mag[k] >> SH);
				quo_s[0][k]  <= '0;
				num_s[0][k]  <= QB'(diff_mag[k]) << FRAC_BITS;
				sneg_s[0][k] <= dzero[k>>1] ? diff_neg[k] : (diff_neg[k] ^ dneg[k>>1]);
				zero_s[0][k] <= diff_mag[k] == '0;
			end
			for (int s = 1; s < NS; s++) begin
				inside_s[s] <= inside_s[s-1];
				for (int k = 0; k < NLANES; k++) begin
					rem_s[s][k]  <= ge_c[s][k] ? (rsh_c[s][k] - RW'(dmag[k>>1])) : rsh_c[s][k];
					quo_s[s][k]  <= {quo_s[s-1][k][QB-2:0], ge_c[s][k]};
					num_s[s][k]  <= num_s[s-1][k] << 1;
					sat_s[s][k]  <= sat_s[s-1][k];
					sneg_s[s][k] <= sneg_s[s-1][k];
					zero_s[s][k] <= zero_s[s-1][k];
				end
			end
			inside_sf <= inside_s[QB];
			for (int k = 0; k < NLANES; k++) begin
				tval_sf[k] <= sneg_s[QB][k] ? -mag_c[k] : mag_c[k];
			end
		end
	end

	assign ctl_out = '{valid: valid_sf, org_in: inside_sf};
	assign slab_t  = tval_sf;

endmodule

// ===== rtl/rbst_back.sv =====
// back stages: slab interval merge, hit decision, hit point
module rbst_back #(
	parameter int COORD_BITS = rbst_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = rbst_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  rbst_pkg::item_ctl_t          ctl_in,
	input  logic signed [COORD_BITS-1:0] slab_t [rbst_pkg::NLANES],
	input  logic signed [COORD_BITS-1:0] org [rbst_pkg::NAXES],
	input  logic        [COORD_BITS-1:0] dmag [rbst_pkg::NAXES],
	input  logic                         dneg [rbst_pkg::NAXES],
	output logic                         res_valid,
	output logic                         did_hit,
	output logic                         origin_inside,
	output logic        [COORD_BITS-2:0] entry_time,
	output logic signed [COORD_BITS-1:0] exit_time,
	output logic        [1:0]            entry_axis,
	output logic                         normal_negative,
	output logic signed [COORD_BITS-1:0] point [rbst_pkg::NAXES]
);
	import rbst_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int NW  = CB - 1;
	localparam int PRW = 2*CB - 1;
	localparam int PW  = PRW - FRAC_BITS;
	localparam int SW  = PW + 2;
	localparam logic [NW-1:0] ONE_Q = {{(NW-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic signed [SW-1:0] S_MAX = (SW'(1) << (CB-1)) - SW'(1);
	localparam logic signed [SW-1:0] S_MIN = -S_MAX - SW'(1);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic in_s1, in_s2, in_s3, in_s4, in_s5;
	logic signed [CB-1:0] amin_s1 [NAXES];
	logic signed [CB-1:0] amax_s1 [NAXES];
	logic signed [CB-1:0] tmin_s2, tmax_s2;
	axis_t                axis_s2, axis_s3, axis_s4, axis_s5;
	logic        [NW-1:0] near_s3, near_s4, near_s5;
	logic signed [CB-1:0] far_s3, far_s4, far_s5;
	logic                 hit_s3, hit_s4, hit_s5;
	logic                 nn_s3, nn_s4, nn_s5;
	logic        [PW-1:0] prod_s4 [NAXES];
	logic signed [CB-1:0] pt_s5 [NAXES];

	logic signed [CB-1:0] tmin_c, tmax_c;
	axis_t                axis_c;
	logic        [NW-1:0] near_c;
	logic                 hit_c, nn_c;
	logic       [PRW-1:0] mul_c [NAXES];
	logic signed [SW-1:0] sum_c [NAXES];
	logic signed [CB-1:0] pt_c [NAXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= ctl_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// latest entry, earliest exit; y beats x on a tie, z only when strictly later
	always_comb begin
		tmin_c = amin_s1[0];
		tmax_c = amax_s1[0];
		for (int i = 1; i < NAXES; i++) begin
			if (amin_s1[i] > tmin_c) begin
				tmin_c = amin_s1[i];
			end
			if (amax_s1[i] < tmax_c) begin
				tmax_c = amax_s1[i];
			end
		end
		if (amin_s1[0] > amin_s1[1]) begin
			axis_c = (amin_s1[2] > amin_s1[0]) ? AXIS_Z : AXIS_X;
		end else begin
			axis_c = (amin_s1[2] > amin_s1[1]) ? AXIS_Z : AXIS_Y;
		end
	end

	always_comb begin
		near_c = (tmin_s2 > 0) ? tmin_s2[NW-1:0] : '0;
		hit_c  = (tmax_s2 > $signed({1'b0, near_c})) && (near_c < ONE_Q) && (tmax_s2 > 0);
		case (axis_s2)
			AXIS_X:  nn_c = !dneg[0];
			AXIS_Y:  nn_c = !dneg[1];
			AXIS_Z:  nn_c = !dneg[2];
			default: nn_c = 1'b0;
		endcase
	end

	always_comb begin
		for (int i = 0; i < NAXES; i++) begin
			mul_c[i] = PRW'(dmag[i]) * PRW'(near_s3);
			if (dneg[i]) begin
				sum_c[i] = SW'(org[i]) - SW'(prod_s4[i]);
			end else begin
				sum_c[i] = SW'(org[i]) + SW'(prod_s4[i]);
			end
			if (sum_c[i] > S_MAX) begin
				pt_c[i] = CB'(S_MAX);
			end else if (sum_c[i] < S_MIN) begin
				pt_c[i] = CB'(S_MIN);
			end else begin
				pt_c[i] = CB'(sum_c[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_s1 <= ctl_in.org_in;
			for (int i = 0; i < NAXES; i++) begin
				amin_s1[i] <= (slab_t[2*i] < slab_t[2*i+1]) ? slab_t[2*i] : slab_t[2*i+1];
				amax_s1[i] <= (slab_t[2*i] < slab_t[2*i+1]) ? slab_t[2*i+1] : slab_t[2*i];
			end

			in_s2   <= in_s1;
			tmin_s2 <= tmin_c;
			tmax_s2 <= tmax_c;
			axis_s2 <= axis_c;

			in_s3   <= in_s2;
			near_s3 <= near_c;
			far_s3  <= tmax_s2;
			axis_s3 <= axis_s2;
			hit_s3  <= hit_c && !in_s2;
			nn_s3   <= nn_c;

			in_s4   <= in_s3;
			near_s4 <= near_s3;
			far_s4  <= far_s3;
			axis_s4 <= axis_s3;
			hit_s4  <= hit_s3;
			nn_s4   <= nn_s3;
			for (int i = 0; i < NAXES; i++) begin
				prod_s4[i] <= PW'(mul_c[i] >> FRAC_BITS);
			end

			// everything but the inside flag reads zero without a hit
			in_s5   <= in_s4;
			hit_s5  <= hit_s4;
			near_s5 <= hit_s4 ? near_s4 : '0;
			far_s5  <= hit_s4 ? far_s4 : '0;
			axis_s5 <= hit_s4 ? axis_s4 : AXIS_X;
			nn_s5   <= hit_s4 && nn_s4;
			for (int i = 0; i < NAXES; i++) begin
				pt_s5[i] <= hit_s4 ? pt_c[i] : '0;
			end
		end
	end

	assign res_valid       = v_s5;
	assign did_hit         = hit_s5;
	assign origin_inside   = in_s5;
	assign entry_time      = near_s5;
	assign exit_time       = far_s5;
	assign entry_axis      = axis_s5;
	assign normal_negative = nn_s5;
	assign point           = pt_s5;

endmodule

// ===== verif/ray_box_slab_test_core_test.sv =====
// testbench of the ray box slab test core: directed, random and back-pressure runs with checking
module ray_box_slab_test_core_test;
	import rbst_pkg::*;

	localparam int CW = 32;
	localparam int IN_TW = 288;
	localparam int OUT_TW = 168;
	localparam longint TMAX = 64'h7fff_ffff;
	localparam longint ONE = 64'h1_0000;
	localparam int LATENCY = 45;
	localparam int LIMIT = 400000;

	typedef struct {
		logic signed [CW-1:0] lo_c[3];
		logic signed [CW-1:0] hi_c[3];
		logic [CW-3:0] grow[3];
	} box_t;

	typedef struct {
		logic hit;
		logic org_in;
		logic [CW-2:0] t_entry;
		logic [CW-1:0] t_exit;
		logic [1:0] axis;
		logic nneg;
		logic [CW-1:0] pt[3];
	} hit_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TW-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TW-1:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CW-1:0] cfg_data = '0;

	// segment settings as the block should hold them
	longint ray_org[3];
	longint ray_dir[3];
	longint ray_margin;
	bit ray_skin;

	hit_rec_t expected_hits[$];
	int n_boxes, n_results, n_hits, n_inside, n_errors, n_cycles;
	bit tx_idle, rx_idle, long_hold_req, took;
	int hold_cnt;

	ray_box_slab_test_core u_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles > LIMIT) begin
			$display("ray_box_slab_test_core_test: errors");
			$finish;
		end
	end

	function automatic longint abs64(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint sat32(longint v);
		if (v > TMAX)
			return TMAX;
		if (v < -TMAX - 1)
			return -TMAX - 1;
		return v;
	endfunction

	// truncating magnitude quotient with 16 fraction bits, clamped
	function automatic longint slab_quot(longint unsigned a, longint unsigned b);
		longint unsigned q, r, res;
		q = a / b;
		r = a % b;
		if (q > (TMAX >> 16))
			return TMAX;
		res = q << 16;
		for (int i = 15; i >= 0; i--) begin
			r = r << 1;
			if (r >= b) begin
				r = r - b;
				res = res | (64'd1 << i);
			end
		end
		return longint'(res);
	endfunction

	function automatic longint slab_time(longint bnd, longint o, longint d);
		longint diff, m;
		diff = bnd - o;
		if (d == 0)
			return diff > 0 ? TMAX : (diff < 0 ? -TMAX : 0);
		m = slab_quot(abs64(diff), abs64(d));
		return ((diff < 0) != (d < 0)) ? -m : m;
	endfunction

	function automatic longint hit_coord(longint o, longint d, longint t);
		longint ad, p;
		ad = abs64(d);
		p = (ad >> 16) * t + (((ad & (ONE - 1)) * t) >> 16);
		return sat32(d < 0 ? o - p : o + p);
	endfunction

	function automatic hit_rec_t predict_hit(box_t b);
		hit_rec_t r;
		longint lo[3], hi[3], amin[3], amax[3];
		longint t1, t2, tmin, tmax, near;
		bit in_box, neg;
		axis_t ax;
		r.hit = 0;
		r.org_in = 0;
		r.t_entry = '0;
		r.t_exit = '0;
		r.axis = '0;
		r.nneg = 0;
		for (int i = 0; i < 3; i++)
			r.pt[i] = '0;
		in_box = 1;
		for (int i = 0; i < 3; i++) begin
			lo[i] = longint'(b.lo_c[i]) - longint'(b.grow[i]);
			hi[i] = longint'(b.hi_c[i]) + longint'(b.grow[i]);
			if (ray_skin)
				in_box &= lo[i] <= ray_org[i] && ray_org[i] <= hi[i];
			else
				in_box &= lo[i] < ray_org[i] && ray_org[i] < hi[i];
		end
		if (in_box) begin
			r.org_in = 1;
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			neg = ray_dir[i] < 0;
			t1 = slab_time(neg ? hi[i] + ray_margin : lo[i] - ray_margin, ray_org[i], ray_dir[i]);
			t2 = slab_time(neg ? lo[i] - ray_margin : hi[i] + ray_margin, ray_org[i], ray_dir[i]);
			amin[i] = t1 < t2 ? t1 : t2;
			amax[i] = t1 < t2 ? t2 : t1;
		end
		tmin = amin[0];
		tmax = amax[0];
		for (int i = 1; i < 3; i++) begin
			if (amin[i] > tmin)
				tmin = amin[i];
			if (amax[i] < tmax)
				tmax = amax[i];
		end
		near = tmin > 0 ? tmin : 0;
		if (amin[0] > amin[1])
			ax = (amin[2] > amin[0]) ? AXIS_Z : AXIS_X;
		else
			ax = (amin[2] > amin[1]) ? AXIS_Z : AXIS_Y;
		if (!(tmax > near && ONE > near && tmax > 0))
			return r;
		r.hit = 1;
		r.t_entry = near[CW-2:0];
		r.t_exit = tmax[CW-1:0];
		r.axis = ax;
		r.nneg = !(ray_dir[ax] < 0);
		for (int i = 0; i < 3; i++)
			r.pt[i] = CW'(hit_coord(ray_org[i], ray_dir[i], near));
		return r;
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [CW-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z: ray_org[idx] = longint'(signed'(v));
			REG_DIR_X, REG_DIR_Y, REG_DIR_Z: ray_dir[idx - REG_DIR_X] = longint'(signed'(v));
			REG_MARGIN: ray_margin = longint'(v[CW-2:0]);
			REG_SKIN_INSIDE: ray_skin = v[0];
			default: ;
		endcase
	endtask

	task automatic set_ray(logic [CW-1:0] ox, oy, oz, dx, dy, dz, mg, logic sk);
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_ORIGIN_Z, oz);
		write_reg(REG_DIR_X, dx);
		write_reg(REG_DIR_Y, dy);
		write_reg(REG_DIR_Z, dz);
		write_reg(REG_MARGIN, mg);
		write_reg(REG_SKIN_INSIDE, {$urandom} << 1 | sk);
	endtask

	// wait until every box in flight has come out
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (expected_hits.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic send_box(box_t b);
		int gap;
		bit ok;
		gap = tx_idle ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		for (int i = 0; i < 3; i++) begin
			s_axis_tdata[CW*i +: CW] <= b.lo_c[i];
			s_axis_tdata[CW*(3+i) +: CW] <= b.hi_c[i];
			s_axis_tdata[6*CW + (CW-2)*i +: CW-2] <= b.grow[i];
		end
		s_axis_tdata[IN_TW-1:6*CW+3*(CW-2)] <= '0;
		do begin
			@(negedge clk);
			ok = s_axis_tready;
			@(posedge clk);
		end while (!ok);
		expected_hits.push_back(predict_hit(b));
		n_boxes++;
	endtask

	function automatic box_t make_box(logic [CW-1:0] x0, y0, z0, x1, y1, z1, logic [CW-3:0] g);
		box_t b;
		b.lo_c[0] = x0;
		b.lo_c[1] = y0;
		b.lo_c[2] = z0;
		b.hi_c[0] = x1;
		b.hi_c[1] = y1;
		b.hi_c[2] = z1;
		for (int i = 0; i < 3; i++)
			b.grow[i] = g;
		return b;
	endfunction

	function automatic logic [CW-1:0] pick_coord();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(0, 1 << 22) - (1 << 21);
			2: case ($urandom_range(0, 4))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'h0001_0000;
				3: return 32'hffff_0000;
				default: return 32'h0;
			endcase
			3: return 32'h0;
			default: return $urandom_range(0, 1 << 26) - (1 << 25);
		endcase
	endfunction

	function automatic box_t random_box();
		box_t b;
		for (int i = 0; i < 3; i++) begin
			b.lo_c[i] = pick_coord();
			b.hi_c[i] = pick_coord();
			b.grow[i] = (CW-2)'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 18));
		end
		return b;
	endfunction

	// a box placed somewhere along the segment so that hits are common
	function automatic box_t box_on_ray();
		box_t b;
		longint c, half;
		for (int i = 0; i < 3; i++) begin
			c = ray_org[i] + ((ray_dir[i] * longint'($urandom_range(0, 90000))) >>> 16);
			half = $urandom_range(0, 1 << $urandom_range(4, 24));
			b.lo_c[i] = CW'(sat32(c - half));
			b.hi_c[i] = CW'(sat32(c + half));
			b.grow[i] = (CW-2)'($urandom_range(0, 1 << $urandom_range(0, 20)));
		end
		return b;
	endfunction

	// receiver stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_axis_tready <= 1'b0;
		end else if (long_hold_req) begin
			long_hold_req <= 1'b0;
			hold_cnt <= 300;
			m_axis_tready <= 1'b0;
		end else if (!m_axis_tready) begin
			m_axis_tready <= 1'b1;
		end else if (took && rx_idle) begin
			int stall;
			stall = $urandom_range(0, 15);
			if (stall > 0) begin
				hold_cnt <= stall - 1;
				m_axis_tready <= 1'b0;
			end
		end
	end

	// result checker, sampled mid-cycle ahead of the transfer edge
	always @(negedge clk) begin
		hit_rec_t e;
		took = arst_n && m_axis_tvalid && m_axis_tready;
		if (took) begin
			if (expected_hits.size() == 0) begin
				$error("result with nothing expected: %h", m_axis_tdata);
				n_errors++;
			end else begin
				e = expected_hits.pop_front();
				n_results++;
				n_hits += e.hit;
				n_inside += e.org_in;
				if (m_axis_tdata[0] !== e.hit) begin
					$error("did_hit exp %0d got %0d", e.hit, m_axis_tdata[0]);
					n_errors++;
				end
				if (m_axis_tdata[1] !== e.org_in) begin
					$error("origin_inside exp %0d got %0d", e.org_in, m_axis_tdata[1]);
					n_errors++;
				end
				if (m_axis_tdata[32:2] !== e.t_entry) begin
					$error("entry_time exp %h got %h", e.t_entry, m_axis_tdata[32:2]);
					n_errors++;
				end
				if (m_axis_tdata[64:33] !== e.t_exit) begin
					$error("exit_time exp %h got %h", e.t_exit, m_axis_tdata[64:33]);
					n_errors++;
				end
				if (m_axis_tdata[66:65] !== e.axis) begin
					$error("entry_axis exp %0d got %0d", e.axis, m_axis_tdata[66:65]);
					n_errors++;
				end
				if (m_axis_tdata[67] !== e.nneg) begin
					$error("normal_negative exp %0d got %0d", e.nneg, m_axis_tdata[67]);
					n_errors++;
				end
				for (int i = 0; i < 3; i++)
					if (m_axis_tdata[68 + CW*i +: CW] !== e.pt[i]) begin
						$error("point_%s exp %h got %h", i == 0 ? "x" : (i == 1 ? "y" : "z"),
							e.pt[i], m_axis_tdata[68 + CW*i +: CW]);
						n_errors++;
					end
			end
		end
	end

	task automatic test_reset_settings;
		send_box(make_box(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
			32'h0002_0000, 32'h0002_0000, 32'h0002_0000, '0));
		send_box(make_box(32'hffff_0000, 32'hffff_0000, 32'hffff_0000,
			32'h0001_0000, 32'h0001_0000, 32'h0001_0000, '0));
		drain();
	endtask

	task automatic test_directed;
		// along +x by ten units, slight +y drift, parallel in z
		set_ray(32'hfffe_0000, 32'h0, 32'h0, 32'h000a_0000, 32'h0000_8000, 32'h0, 32'h0, 1'b0);
		send_box(make_box(32'h0002_0000, 32'hffff_0000, 32'hffff_0000,
			32'h0004_0000, 32'h0001_0000, 32'h0001_0000, '0));
		send_box(make_box(32'hfffa_0000, 32'hffff_0000, 32'hffff_0000,
			32'hfffc_0000, 32'h0001_0000, 32'h0001_0000, '0));
		send_box(make_box(32'hfffd_0000, 32'hffff_0000, 32'hffff_0000,
			32'hffff_0000, 32'h0001_0000, 32'h0001_0000, '0));
		// lower bound exactly at the origin: on the skin, time zero
		send_box(make_box(32'hfffe_0000, 32'h0, 32'hffff_0000,
			32'h0002_0000, 32'h0001_0000, 32'h0001_0000, '0));
		// parallel axis outside the slab
		send_box(make_box(32'h0001_0000, 32'hffff_0000, 32'h0001_0000,
			32'h0002_0000, 32'h0001_0000, 32'h0002_0000, '0));
		// inverted box
		send_box(make_box(32'h0004_0000, 32'h0001_0000, 32'h0001_0000,
			32'h0002_0000, 32'hffff_0000, 32'hffff_0000, '0));
		send_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 30'h3fff_ffff));
		send_box(make_box(32'h7fff_0000, 32'h7fff_0000, 32'h7fff_0000,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, '0));
		send_box(make_box(32'h0001_0000, 32'h8000_0000, 32'h8000_0000,
			32'h0001_0000, 32'h7fff_ffff, 32'h7fff_ffff, 30'h3fff_ffff));
		drain();
		write_reg(REG_SKIN_INSIDE, 32'h1);
		send_box(make_box(32'hfffe_0000, 32'h0, 32'hffff_0000,
			32'h0002_0000, 32'h0001_0000, 32'h0001_0000, '0));
		send_box(make_box(32'hfffe_0000, 32'h0, 32'h0,
			32'hfffe_0000, 32'h0, 32'h0, '0));
		drain();
		// negative, equal directions give entry ties
		set_ray(32'h0004_0000, 32'h0004_0000, 32'h0004_0000, 32'hfff8_0000, 32'hfff8_0000,
			32'hfff8_0000, 32'h0000_4000, 1'b0);
		send_box(make_box(32'hffff_0000, 32'hffff_0000, 32'hffff_0000,
			32'h0001_0000, 32'h0001_0000, 32'h0001_0000, '0));
		send_box(make_box(32'hffff_0000, 32'hffff_0000, 32'hffff_0000,
			32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 30'h100));
		send_box(make_box(32'hffff_0000, 32'hffff_0000, 32'hffff_0000,
			32'h0001_0000, 32'h0001_0000, 32'h0002_0000, '0));
		drain();
		set_ray(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'h7fff_ffff,
			32'h0000_0001, 32'hffff_ffff, 1'b0);
		send_box(make_box(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, '0));
		send_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, '0));
		send_box(make_box(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
			32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 30'h3fff_ffff));
		drain();
	endtask

	task automatic test_random_phases;
		for (int p = 0; p < 7; p++) begin
			tx_idle = p % 3 != 1;
			rx_idle = p % 3 != 2;
			if (p == 0)
				set_ray(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
					32'h8000_0000, 32'h0, 32'h7fff_ffff, 1'b1);
			else
				set_ray($urandom_range(0, 1) ? pick_coord() : $urandom_range(0, 1 << 21),
					pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
					$urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 12),
					$urandom_range(0, 1));
			for (int n = 0; n < 140; n++) begin
				send_box($urandom_range(0, 3) != 0 ? box_on_ray() : random_box());
				if (p == 3 && n == 70)
					drain();
			end
			drain();
		end
	endtask

	task automatic test_back_pressure;
		tx_idle = 0;
		rx_idle = 0;
		set_ray(32'h0, 32'h0, 32'h0, 32'h0010_0000, 32'h0003_0000, 32'hfffd_0000, 32'h80, 1'b0);
		long_hold_req = 1'b1;
		for (int n = 0; n < 60; n++)
			send_box(box_on_ray());
		drain();
	endtask

	initial begin
		for (int i = 0; i < 3; i++) begin
			ray_org[i] = 0;
			ray_dir[i] = 0;
		end
		ray_margin = 0;
		ray_skin = 0;
		tx_idle = 1;
		rx_idle = 1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_settings();
		test_directed();
		test_random_phases();
		test_back_pressure();
		$display("boxes sent %0d, results checked %0d (%0d hits, %0d origin inside)",
			n_boxes, n_results, n_hits, n_inside);
		$display("covered directed cases, seven random segment settings and a long output stall");
		if (n_errors == 0 && expected_hits.size() == 0)
			$display("ray_box_slab_test_core_test: clean");
		else
			$display("ray_box_slab_test_core_test: errors");
		$finish;
	end

endmodule
